>>> rtl/core/skt_pkg.sv
// Shared types, widths and codes for the sorted key table.
// No dependencies; imported by every module of the block.
package skt_pkg;

   localparam int DEPTH = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 32;
   localparam int FIELD_W = 7;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [2:0] status_type;

   localparam status_type ST_FOUND = 3'd0;
   localparam status_type ST_INSERTED = 3'd1;
   localparam status_type ST_NOT_FOUND = 3'd2;
   localparam status_type ST_ZERO_KEY = 3'd3;
   localparam status_type ST_FULL = 3'd4;

   localparam logic CMD_FIND = 1'b0;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_PROBE,
      DP_COMPARE,
      DP_PRIME,
      DP_SHIFT,
      DP_WRITE,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      status_type res;
   } ctl_type;

   typedef struct packed {
      logic zero_key;
      logic cmd;
      logic found;
      logic search_done;
      logic full;
      logic shift_needed;
      logic shift_last;
   } sts_type;

   function automatic field_type to_field(cnt_type v);
      logic [CNT_W+FIELD_W-1:0] ext;
      ext = {{FIELD_W{1'b0}}, v};
      return ext[FIELD_W-1:0];
   endfunction

endpackage

>>> rtl/core/skt_datapath.sv
// Datapath: key memory, search bounds, shift pointer, entry count and result register.
// Depends on skt_pkg; driven by skt_controller through ctl_type commands.
module skt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  skt_pkg::ctl_type     ctl,
   output skt_pkg::sts_type     sts,
   input  logic                 req_cmd,
   input  skt_pkg::key_type     req_lookup_key,
   output skt_pkg::status_type  rsp_status,
   output skt_pkg::field_type   rsp_position,
   output skt_pkg::field_type   rsp_occupancy
);
   import skt_pkg::*;

   key_type mem [DEPTH];
   key_type rdata_ff;

   key_type key_ff;
   logic    cmd_ff;
   cnt_type lo_ff, lo_in;
   cnt_type hi_ff, hi_in;
   cnt_type count_ff, count_in;
   cnt_type wptr_ff, wptr_in;
   logic    found_ff, found_in;

   status_type status_ff;
   field_type  position_ff;
   field_type  occupancy_ff;

   cnt_type  mid;
   cnt_type  raddr_full;
   addr_type raddr;
   logic     we;
   addr_type waddr;
   key_type  wdata;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      raddr_full = mid;
      we = 1'b0;
      waddr = lo_ff[ADDR_W-1:0];
      wdata = key_ff;
      case (ctl.op)
         DP_PRIME: raddr_full = count_ff - cnt_type'(1);
         DP_SHIFT: begin
            raddr_full = wptr_ff - cnt_type'(2);
            we = 1'b1;
            waddr = wptr_ff[ADDR_W-1:0];
            wdata = rdata_ff;
         end
         DP_WRITE: we = 1'b1;
         default: ;
      endcase
      raddr = raddr_full[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      count_in = count_ff;
      wptr_in = wptr_ff;
      found_in = found_ff;
      case (ctl.op)
         DP_LOAD: begin
            lo_in = '0;
            hi_in = count_ff;
            found_in = 1'b0;
         end
         DP_COMPARE: begin
            if (rdata_ff >= key_ff) begin
               hi_in = mid;
            end else begin
               lo_in = mid + cnt_type'(1);
            end
            if (rdata_ff == key_ff) begin
               found_in = 1'b1;
            end
         end
         DP_PRIME: wptr_in = count_ff;
         DP_SHIFT: wptr_in = wptr_ff - cnt_type'(1);
         DP_WRITE: count_in = count_ff + cnt_type'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      wptr_ff <= wptr_in;
      found_ff <= found_in;
      if (ctl.op == DP_LOAD) begin
         key_ff <= req_lookup_key;
         cmd_ff <= req_cmd;
      end
      if (ctl.op == DP_OUT) begin
         status_ff <= ctl.res;
         position_ff <= to_field(lo_ff);
         occupancy_ff <= to_field(count_ff);
      end
   end

   assign sts.zero_key = (key_ff == '0);
   assign sts.cmd = cmd_ff;
   assign sts.found = found_ff;
   assign sts.search_done = (lo_ff == hi_ff);
   assign sts.full = (count_ff == cnt_type'(DEPTH));
   assign sts.shift_needed = (count_ff > lo_ff);
   assign sts.shift_last = (wptr_ff == lo_ff + cnt_type'(1));

   assign rsp_status = status_ff;
   assign rsp_position = position_ff;
   assign rsp_occupancy = occupancy_ff;

endmodule

>>> rtl/core/skt_controller.sv
// Controller: sequences search, shift and insert, and owns the channel handshakes.
// Depends on skt_pkg; commands skt_datapath through ctl_type.
module skt_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  skt_pkg::sts_type  sts,
   output skt_pkg::ctl_type  ctl
);
   import skt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_DECIDE,
      S_PRIME,
      S_SHIFT,
      S_WRITE,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.op = DP_NONE;
      ctl.res = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op = DP_LOAD;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (sts.zero_key) begin
               res_in = ST_ZERO_KEY;
               state_in = S_FINISH;
            end else if (sts.search_done) begin
               state_in = S_DECIDE;
            end else begin
               ctl.op = DP_PROBE;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            ctl.op = DP_COMPARE;
            state_in = S_SEARCH;
         end
         S_DECIDE: begin
            if (sts.found) begin
               res_in = ST_FOUND;
               state_in = S_FINISH;
            end else if (sts.cmd == CMD_FIND) begin
               res_in = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else if (sts.full) begin
               res_in = ST_FULL;
               state_in = S_FINISH;
            end else if (sts.shift_needed) begin
               state_in = S_PRIME;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_PRIME: begin
            ctl.op = DP_PRIME;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            ctl.op = DP_SHIFT;
            if (sts.shift_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ctl.op = DP_WRITE;
            res_in = ST_INSERTED;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               ctl.op = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         res_ff <= ST_FOUND;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         res_ff <= res_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/sorted_key_table_find_or_insert_core.sv
// Top level of the sorted key table: find and find-or-insert on unique nonzero keys.
// Depends on skt_pkg, skt_controller and skt_datapath.
//
// Request channel (req_*): one command and one 32-bit key per transfer.
// Response channel (rsp_*): one status, position and occupancy per request.
// A transfer happens on a rising edge with valid high and stall low.
//
// Each request runs one binary-search probe per halving of the search
// range (memory read, then compare), plus load, decide and handoff. An
// insert adds the key write, and when entries move up, a step to prime
// the read plus one shift step per entry moved; during the shift the key
// memory reads one entry and writes another each cycle. A zero key skips
// the search.
// The response sits in an output register, so a new request is taken while
// a response is still stalled; the next result then waits in its final
// state until the output register frees up.
// Synchronous reset empties the table at once (the entry count is cleared)
// and drops any pending response.
module sorted_key_table_find_or_insert_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  skt_pkg::key_type     req_lookup_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output skt_pkg::status_type  rsp_status,
   output skt_pkg::field_type   rsp_position,
   output skt_pkg::field_type   rsp_occupancy
);
   import skt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   skt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   skt_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_lookup_key (req_lookup_key),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule

>>> rtl/core/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_find_or_insert_core.
module skt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_cmd,
   input skt_pkg::key_type     req_lookup_key,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input skt_pkg::status_type  rsp_status,
   input skt_pkg::field_type   rsp_position,
   input skt_pkg::field_type   rsp_occupancy
);
   import skt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO_KEY |-> rsp_position == '0)
      else $error("zero key reported nonzero position");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == to_field(cnt_type'(DEPTH)))
      else $error("table full reported with spare room");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_cmd)
         && $stable(req_lookup_key))
      else $error("stalled request changed");

endmodule

bind sorted_key_table_find_or_insert_core skt_checker u_skt_checker (.*);
